// ===== rtl/tmr_pkg.sv =====
// ----------------------------------------------------------------------------
// Timer table package
// Shared widths, command and status codes, and the arithmetic unit request.
// ----------------------------------------------------------------------------
package tmr_pkg;

    localparam int DATA_W          = 32;
    localparam int CMD_W           = 3;
    localparam int SLOT_W          = 5;
    localparam int STATUS_W        = 2;
    localparam int CNT_W           = 6;
    localparam int WIDE_IDX_W      = 9;
    localparam int NUM_SLOTS_DEF   = 32;
    localparam int MAX_RESULTS     = 32;

    localparam logic [DATA_W-1:0] MIN_TIMEOUT_RST = 32'd5;

    localparam logic [CMD_W-1:0] CMD_CREATE   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_START    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_STOP     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_STOP_ALL = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TICK     = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd1;

    typedef struct packed {
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic              sub;
    } tmr_alu_req_t;

endpackage

// ===== rtl/tmr_alu.sv =====
// ----------------------------------------------------------------------------
// Timer table adder
// Shared 32-bit add/subtract unit; carry out on subtract means a >= b.
// ----------------------------------------------------------------------------
module tmr_alu
    import tmr_pkg::*;
(
    input  tmr_alu_req_t      req,
    output logic [DATA_W-1:0] sum,
    output logic              carry
);

    logic [DATA_W-1:0] b_op;
    logic [DATA_W:0]   total;

    assign b_op  = req.sub ? ~req.b : req.b;
    assign total = {1'b0, req.a} + {1'b0, b_op} + {{DATA_W{1'b0}}, req.sub};
    assign sum   = total[DATA_W-1:0];
    assign carry = total[DATA_W];

endmodule

// ===== rtl/tmr_mem.sv =====
// ----------------------------------------------------------------------------
// Timer table slot memory
// Start time and period per slot, one write port, one registered read port.
// ----------------------------------------------------------------------------
module tmr_mem
    import tmr_pkg::*;
#(
    parameter int DEPTH = NUM_SLOTS_DEF,
    parameter int AW    = 5
)
(
    input  logic              clk,
    input  logic              start_we,
    input  logic              period_we,
    input  logic [AW-1:0]     waddr,
    input  logic [DATA_W-1:0] start_wdata,
    input  logic [DATA_W-1:0] period_wdata,
    input  logic [AW-1:0]     raddr,
    output logic [DATA_W-1:0] start_rdata,
    output logic [DATA_W-1:0] period_rdata
);

    logic [DATA_W-1:0] start_mem  [DEPTH];
    logic [DATA_W-1:0] period_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (start_we)
        begin
            start_mem[waddr] <= start_wdata;
        end
        if (period_we)
        begin
            period_mem[waddr] <= period_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        start_rdata  <= start_mem[raddr];
        period_rdata <= period_mem[raddr];
    end

endmodule

// ===== rtl/multi_slot_software_timer_table.sv =====
// Commands: create, start, stop, stop all and unknown commands show their one
//   result from the EXEC state through the output register, once it is free.
// Tick: each created slot passes SCAN, an enabled one also ELAP and CMP, and one
//   that fires also UPD and RPT before FLUSH; the 32-bit adder is shared.
// Throughput: one item at a time; ready returns once the last result is loaded.
// Reset: all slots disabled, no slots created, min_timeout 5; no clearing pass.
// ----------------------------------------------------------------------------
// Multi-slot software timer table
// Sequencer around a shared adder and a slot memory; emits fires in slot order.
// ----------------------------------------------------------------------------
module multi_slot_software_timer_table
    import tmr_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [DATA_W-1:0]   cfg_wr_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [CMD_W-1:0]    command,
    input  logic [SLOT_W-1:0]   slot,
    input  logic                repeat_mode,
    input  logic [DATA_W-1:0]   period,
    input  logic [DATA_W-1:0]   now,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] status,
    output logic [SLOT_W-1:0]   slot_out,
    output logic                fired,
    output logic                last
);

    localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = $clog2(NUM_SLOTS + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_ELAP  = 3'd3;
    localparam logic [2:0] S_CMP   = 3'd4;
    localparam logic [2:0] S_UPD   = 3'd5;
    localparam logic [2:0] S_RPT   = 3'd6;
    localparam logic [2:0] S_FLUSH = 3'd7;

    logic [2:0]           state_reg, state_next;
    logic [DATA_W-1:0]    min_timeout_reg;
    logic [CMD_W-1:0]     cmd_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic                 repeat_reg;
    logic [DATA_W-1:0]    period_reg;
    logic [DATA_W-1:0]    now_reg;
    logic [CW-1:0]        created_reg, created_next;
    logic [CW-1:0]        idx_reg, idx_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [SLOT_W-1:0]    pend_slot_reg, pend_slot_next;
    logic [DATA_W-1:0]    elapsed_reg, elapsed_next;
    logic [NUM_SLOTS-1:0] enabled_reg, enabled_next;
    logic [NUM_SLOTS-1:0] repeating_reg;

    logic                 out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [SLOT_W-1:0]    slot_out_reg, slot_out_next;
    logic                 fired_reg, fired_next;
    logic                 last_reg, last_next;

    logic                 accept;
    logic                 out_free;
    logic                 rep_we;
    logic [AW-1:0]        idx_lo;
    logic [AW-1:0]        slot_lo;
    logic                 slot_known;

    tmr_alu_req_t         alu_req;
    logic [DATA_W-1:0]    alu_sum;
    logic                 alu_carry;

    logic                 mem_start_we;
    logic                 mem_period_we;
    logic [AW-1:0]        mem_waddr;
    logic [DATA_W-1:0]    mem_start_wdata;
    logic [DATA_W-1:0]    start_rd;
    logic [DATA_W-1:0]    period_rd;

    assign in_ready   = (state_reg == S_IDLE);
    assign accept     = in_valid && in_ready;
    assign out_free   = !out_valid_reg || out_ready;
    assign idx_lo     = idx_reg[AW-1:0];
    assign slot_lo    = AW'(slot_reg);
    assign slot_known = (WIDE_IDX_W'(slot_reg) < WIDE_IDX_W'(created_reg));

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign slot_out  = slot_out_reg;
    assign fired     = fired_reg;
    assign last      = last_reg;

    tmr_alu u_alu
    (
        .req   (alu_req),
        .sum   (alu_sum),
        .carry (alu_carry)
    );

    tmr_mem #(
        .DEPTH (NUM_SLOTS),
        .AW    (AW)
    ) u_mem
    (
        .clk          (clk),
        .start_we     (mem_start_we),
        .period_we    (mem_period_we),
        .waddr        (mem_waddr),
        .start_wdata  (mem_start_wdata),
        .period_wdata (period_reg),
        .raddr        (idx_lo),
        .start_rdata  (start_rd),
        .period_rdata (period_rd)
    );

    always_comb
    begin
        alu_req.sub = 1'b1;
        case (state_reg)
            S_ELAP:
            begin
                alu_req.a = now_reg;
                alu_req.b = start_rd;
            end
            S_CMP:
            begin
                alu_req.a = elapsed_reg;
                alu_req.b = period_rd;
            end
            S_UPD:
            begin
                alu_req.a   = start_rd;
                alu_req.b   = period_rd;
                alu_req.sub = 1'b0;
            end
            default:
            begin
                alu_req.a = period_reg;
                alu_req.b = min_timeout_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        created_next    = created_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        elapsed_next    = elapsed_reg;
        enabled_next    = enabled_reg;
        rep_we          = 1'b0;
        mem_start_we    = 1'b0;
        mem_period_we   = 1'b0;
        mem_waddr       = slot_lo;
        mem_start_wdata = now_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        status_next     = status_reg;
        slot_out_next   = slot_out_reg;
        fired_next      = fired_reg;
        last_next       = last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (cmd_reg == CMD_TICK)
                begin
                    idx_next        = '0;
                    count_next      = '0;
                    pend_valid_next = 1'b0;
                    state_next      = S_SCAN;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = STATUS_INVALID;
                    slot_out_next  = '0;
                    fired_next     = 1'b0;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                    case (cmd_reg)
                        CMD_CREATE:
                        begin
                            if (created_reg < CW'(NUM_SLOTS))
                            begin
                                rep_we        = 1'b1;
                                status_next   = STATUS_OK;
                                slot_out_next = SLOT_W'(created_reg);
                                created_next  = created_reg + 1'b1;
                            end
                        end
                        CMD_START:
                        begin
                            if (alu_carry && slot_known)
                            begin
                                mem_start_we          = 1'b1;
                                mem_period_we         = 1'b1;
                                enabled_next[slot_lo] = 1'b1;
                                status_next           = STATUS_OK;
                            end
                        end
                        CMD_STOP:
                        begin
                            if (slot_known)
                            begin
                                enabled_next[slot_lo] = 1'b0;
                                status_next           = STATUS_OK;
                            end
                        end
                        CMD_STOP_ALL:
                        begin
                            enabled_next = '0;
                            status_next  = STATUS_OK;
                        end
                        default:
                        begin
                            status_next = STATUS_INVALID;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (idx_reg >= created_reg)
                begin
                    state_next = S_FLUSH;
                end
                else if (!enabled_reg[idx_lo])
                begin
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    state_next = S_ELAP;
                end
            end
            S_ELAP:
            begin
                elapsed_next = alu_sum;
                state_next   = S_CMP;
            end
            S_CMP:
            begin
                if (alu_carry)
                begin
                    state_next = S_UPD;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_UPD:
            begin
                mem_start_we    = 1'b1;
                mem_waddr       = idx_lo;
                mem_start_wdata = alu_sum;
                if (!repeating_reg[idx_lo])
                begin
                    enabled_next[idx_lo] = 1'b0;
                end
                state_next = S_RPT;
            end
            S_RPT:
            begin
                if (count_reg >= CNT_W'(MAX_RESULTS))
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SCAN;
                end
                else if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        status_next    = STATUS_OK;
                        slot_out_next  = pend_slot_reg;
                        fired_next     = 1'b1;
                        last_next      = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_slot_next  = SLOT_W'(idx_reg);
                    count_next      = count_reg + 1'b1;
                    idx_next        = idx_reg + 1'b1;
                    state_next      = S_SCAN;
                end
            end
            S_FLUSH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    status_next     = STATUS_OK;
                    slot_out_next   = pend_valid_reg ? pend_slot_reg : '0;
                    fired_next      = pend_valid_reg;
                    last_next       = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            min_timeout_reg <= MIN_TIMEOUT_RST;
            created_reg     <= '0;
            idx_reg         <= '0;
            count_reg       <= '0;
            pend_valid_reg  <= 1'b0;
            enabled_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            created_reg    <= created_next;
            idx_reg        <= idx_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            enabled_reg    <= enabled_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_wr_en)
            begin
                min_timeout_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= command;
            slot_reg   <= slot;
            repeat_reg <= repeat_mode;
            period_reg <= period;
            now_reg    <= now;
        end
        if (rep_we)
        begin
            repeating_reg[created_reg[AW-1:0]] <= repeat_reg;
        end
        pend_slot_reg <= pend_slot_next;
        elapsed_reg   <= elapsed_next;
        status_reg    <= status_next;
        slot_out_reg  <= slot_out_next;
        fired_reg     <= fired_next;
        last_reg      <= last_next;
    end

endmodule

// ===== rtl/tmr_checker.sv =====
// ----------------------------------------------------------------------------
// Timer table port checker
// Watches the top-level ports for result and handshake consistency.
// ----------------------------------------------------------------------------
module tmr_checker
    import tmr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [STATUS_W-1:0] status,
    input  logic [SLOT_W-1:0]   slot_out,
    input  logic                fired,
    input  logic                last
);

    // hold the result while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(slot_out)
            && $stable(fired) && $stable(last))
        else $error("result changed while stalled");

    // drop ready after each input transaction
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready high right after input transaction");

    a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STATUS_OK |-> last && !fired && slot_out == '0)
        else $error("error result is not a lone final result");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status == STATUS_OK || status == STATUS_INVALID)
        else $error("unexpected status code");

    a_fire_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fired |-> status == STATUS_OK)
        else $error("fired result with error status");

endmodule

bind multi_slot_software_timer_table tmr_checker u_tmr_checker (.*);
